// ===== hw/rtl/rau_pkg.sv =====
// Types and constants shared by the rational arithmetic unit.
// No dependencies.
`default_nettype none
package rau_pkg;
	localparam logic [1:0] ACT_ADD = 2'd0;
	localparam logic [1:0] ACT_SUB = 2'd1;
	localparam logic [1:0] ACT_MUL = 2'd2;
	localparam logic [1:0] ACT_DIV = 2'd3;

	typedef struct packed {
		logic        [1:0]  action;
		logic signed [15:0] a_num;
		logic signed [15:0] a_den;
		logic signed [15:0] b_num;
		logic signed [15:0] b_den;
	} in_item_t;

	typedef struct packed {
		logic signed [32:0] res_num;
		logic        [30:0] res_den;
		logic               error;
	} out_item_t;

	// Classified word handed from the front part to the back part.
	typedef struct packed {
		logic        special;
		logic        error;
		logic        neg;
		logic [31:0] mag;
		logic [30:0] den;
	} job_t;
endpackage
`default_nettype wire

// ===== hw/rtl/rational_arithmetic_unit_top.sv =====
// Top level of the rational arithmetic unit: front, queue and back parts.
// Depends on rau_pkg, rau_front, rau_queue and rau_back.
//
//   channel  | direction | handshake    | word
//   in_word  | in        | push / full  | in_item_t
//   out_word | out       | pop / empty  | out_item_t
//
// The front part takes a new word once its last one has gone to the queue;
// the back part sets the rate. In the back part a word goes through
// stripping common factors of two and binary GCD steps, then two restoring
// divisions; zero and error words go straight to the result register.
// Reset is asynchronous and empties every part. Either side may stall; the
// two-entry queue and the result register let each part run on its own.
`default_nettype none
module rational_arithmetic_unit_top import rau_pkg::*; (
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire in_item_t  in_word,
	input  wire logic      push,
	output logic           full,
	output out_item_t      out_word,
	output logic           empty,
	input  wire logic      pop
);
	job_t f_job, q_job;
	logic f_valid, f_ready, q_valid, q_ready, in_ready, out_valid;

	assign full  = !in_ready;
	assign empty = !out_valid;

	rau_front u_front (
		.clk(clk), .arst_n(arst_n), .in_word(in_word), .in_valid(push),
		.in_ready(in_ready), .job(f_job), .job_valid(f_valid), .job_ready(f_ready)
	);

	rau_queue u_queue (
		.clk(clk), .arst_n(arst_n), .wr_word(f_job), .wr_valid(f_valid),
		.wr_ready(f_ready), .rd_word(q_job), .rd_valid(q_valid), .rd_ready(q_ready)
	);

	rau_back u_back (
		.clk(clk), .arst_n(arst_n), .job(q_job), .job_valid(q_valid),
		.job_ready(q_ready), .out_word(out_word), .out_valid(out_valid),
		.out_ready(pop)
	);
endmodule
`default_nettype wire

// ===== hw/rtl/rau_front.sv =====
// Front part: forms cross products, moves the sign and classifies the word.
// Depends on rau_pkg.
`default_nettype none
module rau_front import rau_pkg::*; (
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire in_item_t  in_word,
	input  wire logic      in_valid,
	output logic           in_ready,
	output job_t           job,
	output logic           job_valid,
	input  wire logic      job_ready
);
	logic        busy_q;
	logic        valid_s1;
	logic [1:0]  act_s1;
	logic        err_s1;
	logic signed [31:0] p0_s1, p1_s1, p2_s1;
	logic signed [33:0] num_c, den_c;
	logic signed [33:0] numf_c, denf_c;
	logic        go_c;

	assign go_c     = in_valid && in_ready;
	assign in_ready = !valid_s1 && !busy_q;

	// Stage one: three registered products.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			if (go_c) begin
				valid_s1 <= 1'b1;
			end else if (valid_s1) begin
				valid_s1 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (go_c) begin
			act_s1 <= in_word.action;
			err_s1 <= (in_word.a_den == 16'sd0) || (in_word.b_den == 16'sd0) ||
			          (in_word.action == ACT_DIV && in_word.b_num == 16'sd0);
			p0_s1  <= (in_word.action == ACT_MUL) ? in_word.a_num * in_word.b_num
			                                      : in_word.a_num * in_word.b_den;
			p1_s1  <= in_word.a_den * in_word.b_num;
			p2_s1  <= in_word.a_den * in_word.b_den;
		end
	end

	// Combine products and put the sign on the numerator.
	always_comb begin
		unique case (act_s1)
			ACT_ADD: begin
				num_c = 34'(p0_s1) + 34'(p1_s1);
				den_c = 34'(p2_s1);
			end
			ACT_SUB: begin
				num_c = 34'(p0_s1) - 34'(p1_s1);
				den_c = 34'(p2_s1);
			end
			ACT_MUL: begin
				num_c = 34'(p0_s1);
				den_c = 34'(p2_s1);
			end
			default: begin
				num_c = 34'(p0_s1);
				den_c = 34'(p1_s1);
			end
		endcase
		numf_c = den_c[33] ? -num_c : num_c;
		denf_c = den_c[33] ? -den_c : den_c;
	end

	// Output register towards the queue.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q    <= 1'b0;
			job_valid <= 1'b0;
		end else begin
			if (valid_s1) begin
				busy_q    <= 1'b1;
				job_valid <= 1'b1;
			end else if (job_valid && job_ready) begin
				busy_q    <= 1'b0;
				job_valid <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s1) begin
			job.error   <= err_s1;
			job.special <= err_s1 || (numf_c == 34'sd0);
			job.neg     <= numf_c[33];
			job.mag     <= numf_c[33] ? 32'(-numf_c) : numf_c[31:0];
			job.den     <= denf_c[30:0];
		end
	end
endmodule
`default_nettype wire

// ===== hw/rtl/rau_queue.sv =====
// Two-entry queue between the front and back parts.
// Depends on rau_pkg.
`default_nettype none
module rau_queue import rau_pkg::*; (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire job_t wr_word,
	input  wire logic wr_valid,
	output logic      wr_ready,
	output job_t      rd_word,
	output logic      rd_valid,
	input  wire logic rd_ready
);
	job_t       mem_q [2];
	logic       wp_q, rp_q;
	logic [1:0] cnt_q;
	logic       wr_c, rd_c;

	assign wr_ready = cnt_q != 2'd2;
	assign rd_valid = cnt_q != 2'd0;
	assign wr_c     = wr_valid && wr_ready;
	assign rd_c     = rd_valid && rd_ready;
	assign rd_word  = mem_q[rp_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= 1'b0;
			rp_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (wr_c) wp_q <= ~wp_q;
			if (rd_c) rp_q <= ~rp_q;
			cnt_q <= cnt_q + 2'(wr_c) - 2'(rd_c);
		end
	end

	always_ff @(posedge clk) begin
		if (wr_c) mem_q[wp_q] <= wr_word;
	end
endmodule
`default_nettype wire

// ===== hw/rtl/rau_back.sv =====
// Back part: binary GCD and two restoring divisions, then the result register.
// Depends on rau_pkg.
`default_nettype none
module rau_back import rau_pkg::*; (
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire job_t  job,
	input  wire logic  job_valid,
	output logic       job_ready,
	output out_item_t  out_word,
	output logic       out_valid,
	input  wire logic  out_ready
);
	typedef enum logic [2:0] {
		ST_IDLE, ST_TWOS, ST_GCD, ST_DIVN, ST_DIVD, ST_DONE
	} state_t;

	state_t      state_q;
	logic [31:0] u_q, v_q;
	logic [4:0]  k_q;
	logic [31:0] g_q;
	logic [31:0] mag_q;
	logic [30:0] den_q;
	logic        neg_q;
	logic        spec_q;
	logic        err_q;
	logic [31:0] dvd_q, quo_q;
	logic [31:0] rem_q;
	logic [5:0]  bit_q;
	logic [32:0] trial_c;
	logic        qbit_c;
	logic [31:0] quo_c;
	logic [31:0] diff_c;
	logic        load_c;

	// The result register is separate, so a new word may start while one waits.
	assign job_ready = state_q == ST_IDLE;
	assign trial_c   = {rem_q, dvd_q[31]};
	assign qbit_c    = trial_c >= {1'b0, g_q};
	assign quo_c     = {quo_q[30:0], qbit_c};
	assign diff_c    = (u_q > v_q) ? u_q - v_q : v_q - u_q;
	assign load_c    = state_q == ST_DONE && (!out_valid || out_ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			out_valid <= 1'b0;
		end else begin
			if (load_c) begin
				out_valid <= 1'b1;
			end else if (out_ready) begin
				out_valid <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (job_valid) begin
						mag_q  <= job.mag;
						den_q  <= job.den;
						neg_q  <= job.neg;
						spec_q <= job.special;
						err_q  <= job.error;
						u_q    <= job.mag;
						v_q    <= {1'b0, job.den};
						k_q    <= 5'd0;
						if (job.special) begin
							state_q <= ST_DONE;
						end else begin
							state_q <= ST_TWOS;
						end
					end
				end
				// Strip common factors of two.
				ST_TWOS: begin
					if (!u_q[0] && !v_q[0]) begin
						u_q <= u_q >> 1;
						v_q <= v_q >> 1;
						k_q <= k_q + 5'd1;
					end else begin
						state_q <= ST_GCD;
					end
				end
				// Stein steps: halve an even operand, else replace by difference.
				ST_GCD: begin
					if (u_q == v_q) begin
						g_q     <= u_q << k_q;
						dvd_q   <= mag_q;
						rem_q   <= 32'd0;
						bit_q   <= 6'd32;
						state_q <= ST_DIVN;
					end else if (!u_q[0]) begin
						u_q <= u_q >> 1;
					end else if (!v_q[0]) begin
						v_q <= v_q >> 1;
					end else if (u_q > v_q) begin
						u_q <= diff_c;
					end else begin
						v_q <= diff_c;
					end
				end
				// Restoring division, one quotient bit a cycle.
				ST_DIVN, ST_DIVD: begin
					quo_q <= quo_c;
					if (bit_q == 6'd1) begin
						if (state_q == ST_DIVN) begin
							mag_q   <= quo_c;
							dvd_q   <= {1'b0, den_q};
							rem_q   <= 32'd0;
							bit_q   <= 6'd32;
							state_q <= ST_DIVD;
						end else begin
							den_q   <= quo_c[30:0];
							state_q <= ST_DONE;
						end
					end else begin
						dvd_q <= dvd_q << 1;
						rem_q <= qbit_c ? 32'(trial_c - {1'b0, g_q}) : trial_c[31:0];
						bit_q <= bit_q - 6'd1;
					end
				end
				// Load the result register once it is free.
				ST_DONE: begin
					if (load_c) begin
						out_word.res_num <= spec_q ? 33'sd0
						                  : (neg_q ? -{1'b0, mag_q} : {1'b0, mag_q});
						out_word.res_den <= spec_q ? 31'd1 : den_q;
						out_word.error   <= err_q;
						state_q          <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end
endmodule
`default_nettype wire

// ===== hw/rtl/rau_checker.sv =====
// Port-level checks of the rational arithmetic unit, bound to the top level.
// Depends on rau_pkg.
`default_nettype none
module rau_checker import rau_pkg::*; (
	input wire logic      clk,
	input wire logic      arst_n,
	input wire logic      push,
	input wire logic      full,
	input wire logic      pop,
	input wire logic      empty,
	input wire out_item_t out_word
);
	// A shown result keeps its word until it is taken.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && !pop |=> !empty && $stable(out_word))
		else $error("result word changed while waiting");

	// The denominator is never zero.
	a_den: assert property (@(posedge clk) disable iff (!arst_n)
		!empty |-> out_word.res_den != 31'd0)
		else $error("zero denominator shown");

	// An error word is always zero over one.
	a_err: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && out_word.error |-> out_word.res_num == 33'sd0 &&
		out_word.res_den == 31'd1)
		else $error("error word not zero over one");

	// The input side only becomes full after it has taken a word.
	a_full: assert property (@(posedge clk) disable iff (!arst_n)
		!full && !push |=> !full)
		else $error("input became full without a word");

	// A result cannot appear in the cycle after reset is left with no input.
	a_rst: assert property (@(posedge clk) $rose(arst_n) |-> empty)
		else $error("result shown out of reset");
endmodule

bind rational_arithmetic_unit_top rau_checker u_rau_checker (
	.clk(clk), .arst_n(arst_n), .push(push), .full(full),
	.pop(pop), .empty(empty), .out_word(out_word)
);
`default_nettype wire
